// ----- rtl/hgp_pkg.sv -----
`default_nettype none

package hgp_pkg;

  localparam int HUE_W     = 16;
  localparam int CH_W      = 8;
  localparam int POS_W     = 11;
  localparam int PIXEL_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Wheel scale: pos = (hue * WHEEL_MAX + HALF) >> HUE_W
  localparam logic [POS_W-1:0]         WHEEL_MAX = 11'd1530;
  localparam logic [HUE_W+POS_W-1:0]   HALF      = 27'd32768;

  localparam logic [POS_W-1:0] POS_SEC1 = 11'd255;
  localparam logic [POS_W-1:0] POS_SEC2 = 11'd510;
  localparam logic [POS_W-1:0] POS_SEC3 = 11'd765;
  localparam logic [POS_W-1:0] POS_SEC4 = 11'd1020;
  localparam logic [POS_W-1:0] POS_SEC5 = 11'd1275;

  localparam logic [CH_W-1:0] CH_FULL = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

  localparam logic [CH_W-1:0] SAT_RESET = 8'd255;
  localparam logic [CH_W-1:0] BRI_RESET = 8'd75;

  typedef struct packed {
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] bri;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ----- rtl/hsv_to_grbw_pixel_top.sv -----
`default_nettype none

// Hue to GRBW pixel converter. One hue is taken on every clock where start
// is high (busy stays low), and its pixel word is held on out_pixel_word
// with a one-cycle out_valid strobe that ends at a rising edge; the result
// must be captured at that edge. The hue passes through two register stages
// in the wheel (hue scale multiply, then rounding and sector ramp) and two in
// each channel blend (saturation, then brightness). Saturation and brightness
// are written through cfg_we/cfg_index/cfg_data and should only change while
// no transaction is in flight.
module hsv_to_grbw_pixel_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [hgp_pkg::HUE_W-1:0]         in_hue,
  output logic                                   out_valid,
  output logic [hgp_pkg::PIXEL_W-1:0]            out_pixel_word,
  input  wire logic                              cfg_we,
  input  wire logic [hgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hgp_pkg::CH_W-1:0]          cfg_data
);

  hgp_pkg::cfg_t cfg_r;
  hgp_pkg::rgb_t wheel_rgb;
  logic          wheel_vld;
  logic          accept;
  logic [2:0]    ch_vld;
  logic [hgp_pkg::CH_W-1:0] red_out;
  logic [hgp_pkg::CH_W-1:0] green_out;
  logic [hgp_pkg::CH_W-1:0] blue_out;

  // The pipeline takes a transaction every cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sat <= hgp_pkg::SAT_RESET;
      cfg_r.bri <= hgp_pkg::BRI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgp_pkg::REG_SATURATION: cfg_r.sat <= cfg_data;
        hgp_pkg::REG_BRIGHTNESS: cfg_r.bri <= cfg_data;
        default: ;
      endcase
    end
  end

  hgp_wheel u_wheel (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (accept),
    .hue     (in_hue),
    .vld_out (wheel_vld),
    .rgb_out (wheel_rgb)
  );

  hgp_blend u_blend_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .vld_in  (wheel_vld),
    .ch_in   (wheel_rgb.red),
    .vld_out (ch_vld[0]),
    .ch_out  (red_out)
  );

  hgp_blend u_blend_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .vld_in  (wheel_vld),
    .ch_in   (wheel_rgb.green),
    .vld_out (ch_vld[1]),
    .ch_out  (green_out)
  );

  hgp_blend u_blend_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .vld_in  (wheel_vld),
    .ch_in   (wheel_rgb.blue),
    .vld_out (ch_vld[2]),
    .ch_out  (blue_out)
  );

  assign out_valid      = ch_vld[0];
  assign out_pixel_word = {green_out, red_out, blue_out, {hgp_pkg::CH_W{1'b0}}};

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a transaction four cycles earlier");
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_vld == 3'b000) || (ch_vld == 3'b111))
    else $error("channel lanes out of step");
`endif

endmodule

`default_nettype wire

// ----- rtl/hgp_wheel.sv -----
`default_nettype none

module hgp_wheel (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_in,
  input  wire logic [hgp_pkg::HUE_W-1:0] hue,
  output logic                          vld_out,
  output hgp_pkg::rgb_t                 rgb_out
);

  localparam int PROD_W = hgp_pkg::HUE_W + hgp_pkg::POS_W;

  logic              v1_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic              v2_r;
  hgp_pkg::rgb_t     rgb_r;
  hgp_pkg::rgb_t     rgb_nxt;
  logic [PROD_W-1:0] rounded;
  logic [hgp_pkg::POS_W-1:0] pos;
  logic [hgp_pkg::POS_W-1:0] down;
  logic [hgp_pkg::POS_W-1:0] up;

  assign prod_nxt = PROD_W'(hue) * PROD_W'(hgp_pkg::WHEEL_MAX);
  assign rounded  = prod_r + hgp_pkg::HALF;
  assign pos      = rounded[PROD_W-1:hgp_pkg::HUE_W];

  // Six-sector ramp; the final sector wraps back to pure red.
  always_comb begin
    rgb_nxt = '0;
    up      = '0;
    down    = '0;
    if (pos < hgp_pkg::POS_SEC2) begin
      if (pos < hgp_pkg::POS_SEC1) begin
        rgb_nxt.red   = hgp_pkg::CH_FULL;
        rgb_nxt.green = pos[hgp_pkg::CH_W-1:0];
      end else begin
        down          = hgp_pkg::POS_SEC2 - pos;
        rgb_nxt.red   = down[hgp_pkg::CH_W-1:0];
        rgb_nxt.green = hgp_pkg::CH_FULL;
      end
    end else if (pos < hgp_pkg::POS_SEC4) begin
      if (pos < hgp_pkg::POS_SEC3) begin
        up            = pos - hgp_pkg::POS_SEC2;
        rgb_nxt.green = hgp_pkg::CH_FULL;
        rgb_nxt.blue  = up[hgp_pkg::CH_W-1:0];
      end else begin
        down          = hgp_pkg::POS_SEC4 - pos;
        rgb_nxt.green = down[hgp_pkg::CH_W-1:0];
        rgb_nxt.blue  = hgp_pkg::CH_FULL;
      end
    end else if (pos < hgp_pkg::WHEEL_MAX) begin
      if (pos < hgp_pkg::POS_SEC5) begin
        up           = pos - hgp_pkg::POS_SEC4;
        rgb_nxt.red  = up[hgp_pkg::CH_W-1:0];
        rgb_nxt.blue = hgp_pkg::CH_FULL;
      end else begin
        down         = hgp_pkg::WHEEL_MAX - pos;
        rgb_nxt.red  = hgp_pkg::CH_FULL;
        rgb_nxt.blue = down[hgp_pkg::CH_W-1:0];
      end
    end else begin
      rgb_nxt.red = hgp_pkg::CH_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
    prod_r <= prod_nxt;
    rgb_r  <= rgb_nxt;
  end

  assign vld_out = v2_r;
  assign rgb_out = rgb_r;

`ifndef SYNTH
  // Every wheel color has one channel at full and one at zero.
  a_one_full: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rgb_r.red == hgp_pkg::CH_FULL || rgb_r.green == hgp_pkg::CH_FULL ||
              rgb_r.blue == hgp_pkg::CH_FULL))
    else $error("wheel output lacks a full channel");
  a_one_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rgb_r.red == '0 || rgb_r.green == '0 || rgb_r.blue == '0))
    else $error("wheel output lacks a zero channel");
`endif

endmodule

`default_nettype wire

// ----- rtl/hgp_blend.sv -----
`default_nettype none

module hgp_blend (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire hgp_pkg::cfg_t             cfg,
  input  wire logic                      vld_in,
  input  wire logic [hgp_pkg::CH_W-1:0]  ch_in,
  output logic                           vld_out,
  output logic [hgp_pkg::CH_W-1:0]       ch_out
);

  localparam int W  = hgp_pkg::CH_W;
  localparam int PW = 2 * W + 1;

  logic          va_r;
  logic [W-1:0]  mixed_r;
  logic [W-1:0]  mixed_nxt;
  logic          vb_r;
  logic [W-1:0]  ch_r;
  logic [W-1:0]  ch_nxt;
  logic [PW-1:0] sat_prod;
  logic [PW-1:0] bri_prod;
  logic [W:0]    mix_sum;

  // Blend toward white; the sum never exceeds a channel's full scale.
  assign sat_prod  = PW'(ch_in) * (PW'(cfg.sat) + PW'(1));
  assign mix_sum   = sat_prod[PW-1:W] + (W+1)'(hgp_pkg::CH_FULL - cfg.sat);
  assign mixed_nxt = mix_sum[W-1:0];

  assign bri_prod = PW'(mixed_r) * (PW'(cfg.bri) + PW'(1));
  assign ch_nxt   = bri_prod[2*W-1:W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= vld_in;
      vb_r <= va_r;
    end
    mixed_r <= mixed_nxt;
    ch_r    <= ch_nxt;
  end

  assign vld_out = vb_r;
  assign ch_out  = ch_r;

`ifndef SYNTH
  // Zero saturation with full brightness gives pure full scale.
  a_white_full: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && $past(cfg.sat == '0, 2) && $past(cfg.bri == hgp_pkg::CH_FULL, 1))
      |-> (ch_r == hgp_pkg::CH_FULL))
    else $error("white blend at full brightness is not full scale");
  a_vld_follow: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> $past(vld_in, 2))
    else $error("blend valid without a prior input");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

import hgp_pkg::*;

class pixel_ledger;
  typedef struct {
    logic [HUE_W-1:0]   hue;
    logic [PIXEL_W-1:0] pixel;
  } pixel_entry_t;

  pixel_entry_t     pending_pixels[$];
  logic [CH_W-1:0]  sat;
  logic [CH_W-1:0]  bri;
  int               error_count;

  function new();
    sat = SAT_RESET;
    bri = BRI_RESET;
    error_count = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] val);
    case (idx)
      REG_SATURATION: sat = val;
      REG_BRIGHTNESS: bri = val;
      default: ;
    endcase
  endfunction

  // Mix toward white by saturation, then scale by brightness.
  function logic [CH_W-1:0] blend(int unsigned c);
    int unsigned mixed;
    mixed = ((c * (int'(sat) + 1)) >> 8) + (int'(CH_FULL) - int'(sat));
    return CH_W'((mixed * (int'(bri) + 1)) >> 8);
  endfunction

  function logic [PIXEL_W-1:0] predict_grbw(logic [HUE_W-1:0] hue);
    int unsigned h, pos, r, g, b, full, sec1, sec2, sec3, sec4, sec5, wmax;
    h    = hue;
    full = CH_FULL;
    sec1 = POS_SEC1;
    sec2 = POS_SEC2;
    sec3 = POS_SEC3;
    sec4 = POS_SEC4;
    sec5 = POS_SEC5;
    wmax = WHEEL_MAX;
    pos  = (h * wmax + int'(HALF)) >> HUE_W;
    if (pos < sec2) begin
      b = 0;
      if (pos < sec1) begin
        r = full;
        g = pos;
      end else begin
        r = sec2 - pos;
        g = full;
      end
    end else if (pos < sec4) begin
      r = 0;
      if (pos < sec3) begin
        g = full;
        b = pos - sec2;
      end else begin
        g = sec4 - pos;
        b = full;
      end
    end else if (pos < wmax) begin
      g = 0;
      if (pos < sec5) begin
        r = pos - sec4;
        b = full;
      end else begin
        r = full;
        b = wmax - pos;
      end
    end else begin
      // top of the wheel wraps to pure red
      r = full;
      g = 0;
      b = 0;
    end
    return {blend(g), blend(r), blend(b), 8'h00};
  endfunction

  function void note_hue(logic [HUE_W-1:0] hue);
    pixel_entry_t e;
    e.hue   = hue;
    e.pixel = predict_grbw(hue);
    pending_pixels.push_back(e);
  endfunction

  function void report(string what, logic [HUE_W-1:0] hue, logic [PIXEL_W-1:0] want,
                       logic [PIXEL_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("ERROR: %s hue=%h expected=%h actual=%h", what, hue, want, got);
  endfunction

  function void check_pixel(logic [PIXEL_W-1:0] got);
    pixel_entry_t e;
    if (pending_pixels.size() == 0) begin
      report("pixel word with no transaction pending", 'x, 'x, got);
    end else begin
      e = pending_pixels.pop_front();
      if (got !== e.pixel)
        report("pixel word mismatch", e.hue, e.pixel, got);
    end
  endfunction

  function int outstanding();
    return pending_pixels.size();
  endfunction

  function void flush_leftover();
    pixel_entry_t e;
    while (pending_pixels.size() != 0) begin
      e = pending_pixels.pop_front();
      report("pixel word never produced", e.hue, e.pixel, 'x);
    end
  endfunction
endclass

module testbench;
  localparam int PHASES     = 8;
  localparam int PHASE_HUES = 80;
  localparam int DRAIN      = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [HUE_W-1:0]   in_hue;
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel_word;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CH_W-1:0]    cfg_data;

  pixel_ledger ledger;

  hsv_to_grbw_pixel_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_hue         (in_hue),
    .out_valid      (out_valid),
    .out_pixel_word (out_pixel_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note the transaction before checking so a short pipeline still lines up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we)
        ledger.write_reg(cfg_index, cfg_data);
      if (start && !busy)
        ledger.note_hue(in_hue);
      if (out_valid)
        ledger.check_pixel(out_pixel_word);
    end
  end

  // Lowest hue that lands on wheel position pos.
  function automatic int unsigned hue_for_pos(int unsigned pos);
    if (pos == 0)
      return 0;
    return (pos * 65536 - int'(HALF) + int'(WHEEL_MAX) - 1) / int'(WHEEL_MAX);
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned h;
    case ($urandom_range(0, 9))
      0, 1: begin
        h = hue_for_pos($urandom_range(1, 6) * int'(POS_SEC1)) + $urandom_range(0, 4) - 2;
      end
      2: h = $urandom_range(65500, 65535);
      default: h = $urandom_range(0, 65535);
    endcase
    return HUE_W'(h);
  endfunction

  task automatic send_hue(input logic [HUE_W-1:0] hue);
    @(negedge clk);
    start  <= 1'b1;
    in_hue <= hue;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start, wait for every pixel word, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CH_W-1:0] sat_set[PHASES];
    logic [CH_W-1:0] bri_set[PHASES];
    int sent, burst, j;
    bit steady;

    start     = 1'b0;
    in_hue    = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SATURATION;
    cfg_data  = '0;
    rst_n     = 1'b0;
    ledger    = new();

    sat_set = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd1,   8'd254, 8'd0, 8'd0};
    bri_set = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd254, 8'd1,   8'd0, 8'd0};
    for (j = PHASES - 2; j < PHASES; j++) begin
      sat_set[j] = CH_W'($urandom_range(0, 255));
      bri_set[j] = CH_W'($urandom_range(0, 255));
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: hue extremes, alternating bits and both sides of each sector edge.
    send_hue(16'h0000);
    send_hue(16'hFFFF);
    send_hue(16'h5555);
    send_hue(16'hAAAA);
    for (j = 1; j <= 6; j++) begin
      send_hue(HUE_W'(hue_for_pos(j * int'(POS_SEC1)) - 1));
      send_hue(HUE_W'(hue_for_pos(j * int'(POS_SEC1))));
    end
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase % 2 == 0) begin
        write_reg(REG_SATURATION, sat_set[phase]);
        write_reg(REG_BRIGHTNESS, bri_set[phase]);
      end else begin
        write_reg(REG_BRIGHTNESS, bri_set[phase]);
        write_reg(REG_SATURATION, sat_set[phase]);
      end
      steady = (phase % 3 == 0);
      sent = 0;
      while (sent < PHASE_HUES) begin
        burst = $urandom_range(1, 24);
        for (j = 0; j < burst && sent < PHASE_HUES; j++) begin
          send_hue(pick_hue());
          sent++;
        end
        if (!steady)
          pause($urandom_range(0, 5));
      end
      settle();
    end

    ledger.flush_leftover();
    if (ledger.error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire
